FILE: hw/rtl/sss_pkg.sv
package sss_pkg;

   localparam int SAMPLES_PER_READ_DEF = 1;
   localparam int READ_COUNT_MAX = 64;
   localparam int READ_COUNT_W = 7;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int MV_W = 16;
   localparam int VAL_W = 32;
   localparam int DMV_W = MV_W + 1;
   localparam int DSC_W = VAL_W + 1;
   localparam int PROD_W = DMV_W + DSC_W;
   localparam int MAG_W = 48;
   localparam int DEN_W = MV_W;
   localparam int SUM_W = MAG_W + 2;
   localparam int CNT_W = $clog2(MAG_W);

   typedef enum logic [2:0] {
      REG_ENABLED,
      REG_POWER_SWITCHED,
      REG_SAMPLE_INTERVAL,
      REG_SETTLING_TIME,
      REG_VOLT_LOW_MV,
      REG_VOLT_HIGH_MV,
      REG_SCALE_LOW,
      REG_SCALE_HIGH
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_IDLE,
      STATUS_ACTIVE,
      STATUS_ERROR
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_EVAL,
      CTL_WAIT,
      CTL_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {
      AR_IDLE,
      AR_MUL,
      AR_DIV,
      AR_FIX
   } arith_state_type;

   typedef struct packed {
      logic                    enabled;
      logic                    power_switched;
      logic [31:0]             sample_interval;
      logic [31:0]             settling_time;
      logic signed [MV_W-1:0]  volt_low_mv;
      logic signed [MV_W-1:0]  volt_high_mv;
      logic signed [VAL_W-1:0] scale_low;
      logic signed [VAL_W-1:0] scale_high;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      enabled:         1'b0,
      power_switched:  1'b0,
      sample_interval: 32'd1000,
      settling_time:   32'd0,
      volt_low_mv:     16'sd0,
      volt_high_mv:    16'sd3300,
      scale_low:       32'sd0,
      scale_high:      32'sd100000
   };

   typedef struct packed {
      logic                   start;
      logic signed [MV_W-1:0] mv;
   } arith_cmd_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic signed [VAL_W-1:0] value;
   } arith_rsp_type;

   function automatic logic [READ_COUNT_W-1:0] read_count_clamp(input int n);
      int c;
      c = n;
      if (c < 1) begin
         c = 1;
      end
      if (c > READ_COUNT_MAX) begin
         c = READ_COUNT_MAX;
      end
      return READ_COUNT_W'(c);
   endfunction

endpackage

FILE: hw/rtl/sss_csr.sv
module sss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sss_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [sss_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sss_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output sss_pkg::cfg_type                    cfg
);

   sss_pkg::cfg_type       cfg_ff;
   sss_pkg::cfg_type       cfg_in;
   sss_pkg::reg_index_type index;
   logic                   wr_en;

   assign index = sss_pkg::reg_index_type'(paddr[sss_pkg::CSR_ADDR_W-1:2]);
   assign wr_en = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            sss_pkg::REG_ENABLED:         cfg_in.enabled = pwdata[0];
            sss_pkg::REG_POWER_SWITCHED:  cfg_in.power_switched = pwdata[0];
            sss_pkg::REG_SAMPLE_INTERVAL: cfg_in.sample_interval = pwdata;
            sss_pkg::REG_SETTLING_TIME:   cfg_in.settling_time = pwdata;
            sss_pkg::REG_VOLT_LOW_MV:     cfg_in.volt_low_mv = pwdata[sss_pkg::MV_W-1:0];
            sss_pkg::REG_VOLT_HIGH_MV:    cfg_in.volt_high_mv = pwdata[sss_pkg::MV_W-1:0];
            sss_pkg::REG_SCALE_LOW:       cfg_in.scale_low = pwdata;
            sss_pkg::REG_SCALE_HIGH:      cfg_in.scale_high = pwdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         sss_pkg::REG_ENABLED:         prdata = {31'd0, cfg_ff.enabled};
         sss_pkg::REG_POWER_SWITCHED:  prdata = {31'd0, cfg_ff.power_switched};
         sss_pkg::REG_SAMPLE_INTERVAL: prdata = cfg_ff.sample_interval;
         sss_pkg::REG_SETTLING_TIME:   prdata = cfg_ff.settling_time;
         sss_pkg::REG_VOLT_LOW_MV:     prdata = {16'd0, cfg_ff.volt_low_mv};
         sss_pkg::REG_VOLT_HIGH_MV:    prdata = {16'd0, cfg_ff.volt_high_mv};
         sss_pkg::REG_SCALE_LOW:       prdata = cfg_ff.scale_low;
         sss_pkg::REG_SCALE_HIGH:      prdata = cfg_ff.scale_high;
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= sss_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/sss_arith.sv
module sss_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  sss_pkg::cfg_type       cfg,
   input  sss_pkg::arith_cmd_type cmd,
   output sss_pkg::arith_rsp_type rsp
);

   localparam int MAG_W = sss_pkg::MAG_W;
   localparam int DEN_W = sss_pkg::DEN_W;
   localparam int SUM_W = sss_pkg::SUM_W;
   localparam int VAL_W = sss_pkg::VAL_W;
   localparam int CNT_W = sss_pkg::CNT_W;

   sss_pkg::arith_state_type st_ff, st_in;

   logic signed [sss_pkg::DMV_W-1:0]  dmv_ff, dmv_in;
   logic signed [sss_pkg::DSC_W-1:0]  dsc_ff, dsc_in;
   logic [DEN_W-1:0]                  den_ff, den_in;
   logic                              den_neg_ff, den_neg_in;
   logic signed [VAL_W-1:0]           slo_ff, slo_in;
   logic [MAG_W-1:0]                  mag_ff, mag_in;
   logic [DEN_W-1:0]                  rem_ff, rem_in;
   logic                              qneg_ff, qneg_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic signed [VAL_W-1:0]           result_ff, result_in;
   logic                              done_ff, done_in;

   logic signed [sss_pkg::DMV_W-1:0]  vspan;
   logic signed [sss_pkg::DMV_W-1:0]  vspan_abs;
   logic signed [sss_pkg::DMV_W-1:0]  dmv_start;
   logic signed [sss_pkg::DSC_W-1:0]  dsc_start;
   logic signed [sss_pkg::PROD_W-1:0] prod;
   logic signed [sss_pkg::PROD_W-1:0] prod_abs;
   logic [DEN_W:0]                    trial;
   logic [DEN_W:0]                    diff;
   logic                              ge;
   logic signed [MAG_W:0]             q_ext;
   logic signed [MAG_W:0]             q_signed;
   logic signed [SUM_W-1:0]           sum;
   logic                              fits;

   assign vspan = $signed({cfg.volt_high_mv[sss_pkg::MV_W-1], cfg.volt_high_mv})
                - $signed({cfg.volt_low_mv[sss_pkg::MV_W-1], cfg.volt_low_mv});
   assign vspan_abs = vspan[sss_pkg::DMV_W-1] ? -vspan : vspan;
   assign dmv_start = $signed({cmd.mv[sss_pkg::MV_W-1], cmd.mv})
                    - $signed({cfg.volt_low_mv[sss_pkg::MV_W-1], cfg.volt_low_mv});
   assign dsc_start = $signed({cfg.scale_high[VAL_W-1], cfg.scale_high})
                    - $signed({cfg.scale_low[VAL_W-1], cfg.scale_low});

   assign prod = dmv_ff * dsc_ff;
   assign prod_abs = prod[sss_pkg::PROD_W-1] ? -prod : prod;

   assign trial = {rem_ff, mag_ff[MAG_W-1]};
   assign diff = trial - {1'b0, den_ff};
   assign ge = trial >= {1'b0, den_ff};

   assign q_ext = $signed({1'b0, mag_ff});
   assign q_signed = qneg_ff ? -q_ext : q_ext;
   assign sum = $signed({q_signed[MAG_W], q_signed})
              + $signed({{(SUM_W-VAL_W){slo_ff[VAL_W-1]}}, slo_ff});
   assign fits = (&sum[SUM_W-1:VAL_W-1]) | ~(|sum[SUM_W-1:VAL_W-1]);

   always_comb begin
      st_in = st_ff;
      dmv_in = dmv_ff;
      dsc_in = dsc_ff;
      den_in = den_ff;
      den_neg_in = den_neg_ff;
      slo_in = slo_ff;
      mag_in = mag_ff;
      rem_in = rem_ff;
      qneg_in = qneg_ff;
      cnt_in = cnt_ff;
      result_in = result_ff;
      done_in = 1'b0;
      case (st_ff)
         sss_pkg::AR_IDLE: begin
            if (cmd.start) begin
               dmv_in = dmv_start;
               dsc_in = dsc_start;
               den_in = vspan_abs[DEN_W-1:0];
               den_neg_in = vspan[sss_pkg::DMV_W-1];
               slo_in = cfg.scale_low;
               if (vspan == '0) begin
                  mag_in = '0;
                  qneg_in = 1'b0;
                  st_in = sss_pkg::AR_FIX;
               end else begin
                  st_in = sss_pkg::AR_MUL;
               end
            end
         end
         sss_pkg::AR_MUL: begin
            mag_in = prod_abs[MAG_W-1:0];
            qneg_in = prod[sss_pkg::PROD_W-1] ^ den_neg_ff;
            rem_in = '0;
            cnt_in = '0;
            st_in = sss_pkg::AR_DIV;
         end
         sss_pkg::AR_DIV: begin
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            mag_in = {mag_ff[MAG_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               st_in = sss_pkg::AR_FIX;
            end
         end
         sss_pkg::AR_FIX: begin
            if (fits) begin
               result_in = sum[VAL_W-1:0];
            end else if (sum[SUM_W-1]) begin
               result_in = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
               result_in = {1'b0, {(VAL_W-1){1'b1}}};
            end
            done_in = 1'b1;
            st_in = sss_pkg::AR_IDLE;
         end
         default: begin
            st_in = sss_pkg::AR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sss_pkg::AR_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dmv_ff <= dmv_in;
      dsc_ff <= dsc_in;
      den_ff <= den_in;
      den_neg_ff <= den_neg_in;
      slo_ff <= slo_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      qneg_ff <= qneg_in;
      cnt_ff <= cnt_in;
      result_ff <= result_in;
   end

   assign rsp.busy = (st_ff != sss_pkg::AR_IDLE);
   assign rsp.done = done_ff;
   assign rsp.value = result_ff;

endmodule

FILE: hw/rtl/powered_sensor_sample_scaler_top.sv
// Powered sensor sample scaler. Each input transaction is one millisecond tick and
// produces exactly one result transaction. A tick that does not latch a new sample
// passes from the evaluate state to the done state and then into the output register.
// A tick that latches a sample runs the multiply/divide unit: a multiply step, 48
// restoring divide steps at one quotient bit per cycle, a step that adds the offset
// and saturates, and a handoff through the wait and done states. When the voltage
// span is zero the multiply and divide are skipped and only the offset step runs.
// req_ready rises in the cycle the result is presented, and the next tick can be
// accepted from then on. A finished result may wait in the output register while
// the next tick is accepted and worked on; a tick whose result finds that register
// still full waits until rsp_ready frees it.
module powered_sensor_sample_scaler_top #(
   parameter int SAMPLES_PER_READ = sss_pkg::SAMPLES_PER_READ_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [31:0]                           req_now_ms,
   input  logic [31:0]                           req_power_on_ms,
   input  logic                                  req_channel_ready,
   input  logic                                  req_read_ok,
   input  logic signed [sss_pkg::MV_W-1:0]       req_reading_raw,
   input  logic signed [sss_pkg::MV_W-1:0]       req_reading_mv,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_power_request,
   output logic                                  rsp_power_release,
   output logic                                  rsp_sample_taken,
   output logic [sss_pkg::READ_COUNT_W-1:0]      rsp_read_count,
   output logic                                  rsp_value_valid,
   output logic signed [sss_pkg::MV_W-1:0]       rsp_held_raw,
   output logic signed [sss_pkg::VAL_W-1:0]      rsp_held_value,

   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [sss_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [sss_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [sss_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);

   localparam logic [sss_pkg::READ_COUNT_W-1:0] READ_COUNT =
      sss_pkg::read_count_clamp(SAMPLES_PER_READ);

   sss_pkg::cfg_type       cfg;
   sss_pkg::arith_cmd_type arith_cmd;
   sss_pkg::arith_rsp_type arith_rsp;

   sss_pkg::ctl_state_type st_ff, st_in;

   logic [31:0]                      now_ff, now_in;
   logic [31:0]                      pon_ff, pon_in;
   logic                             chrdy_ff, chrdy_in;
   logic                             ok_ff, ok_in;
   logic signed [sss_pkg::MV_W-1:0]  raw_ff, raw_in;
   logic signed [sss_pkg::MV_W-1:0]  mv_ff, mv_in;

   logic                             settling_ff, settling_in;
   logic                             have_ff, have_in;
   logic [31:0]                      last_ms_ff, last_ms_in;
   logic signed [sss_pkg::MV_W-1:0]  last_raw_ff, last_raw_in;
   logic signed [sss_pkg::VAL_W-1:0] last_value_ff, last_value_in;

   sss_pkg::status_type              status_ff, status_in;
   logic                             preq_ff, preq_in;
   logic                             prel_ff, prel_in;
   logic                             took_ff, took_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   sss_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                             rsp_preq_ff, rsp_preq_in;
   logic                             rsp_prel_ff, rsp_prel_in;
   logic                             rsp_took_ff, rsp_took_in;
   logic                             rsp_have_ff, rsp_have_in;
   logic signed [sss_pkg::MV_W-1:0]  rsp_raw_ff, rsp_raw_in;
   logic signed [sss_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;

   logic [31:0] since_sample;
   logic [31:0] since_power;
   logic        active;
   logic        hold;
   logic        go_settle;
   logic        settle_wait;
   logic        do_sample;

   sss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sss_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .cmd   (arith_cmd),
      .rsp   (arith_rsp)
   );

   assign since_sample = now_ff - last_ms_ff;
   assign since_power = now_ff - pon_ff;
   assign active = chrdy_ff & cfg.enabled;
   assign hold = ~settling_ff & have_ff & (since_sample < cfg.sample_interval);
   assign go_settle = ~settling_ff & ~hold & cfg.power_switched;
   assign settle_wait = (settling_ff | go_settle) & (cfg.settling_time != 32'd0)
                      & (since_power < cfg.settling_time);
   assign do_sample = ~hold & ~settle_wait;

   assign req_ready = (st_ff == sss_pkg::CTL_IDLE);

   always_comb begin
      st_in = st_ff;
      now_in = now_ff;
      pon_in = pon_ff;
      chrdy_in = chrdy_ff;
      ok_in = ok_ff;
      raw_in = raw_ff;
      mv_in = mv_ff;
      settling_in = settling_ff;
      have_in = have_ff;
      last_ms_in = last_ms_ff;
      last_raw_in = last_raw_ff;
      last_value_in = last_value_ff;
      status_in = status_ff;
      preq_in = preq_ff;
      prel_in = prel_ff;
      took_in = took_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_preq_in = rsp_preq_ff;
      rsp_prel_in = rsp_prel_ff;
      rsp_took_in = rsp_took_ff;
      rsp_have_in = rsp_have_ff;
      rsp_raw_in = rsp_raw_ff;
      rsp_value_in = rsp_value_ff;
      arith_cmd.start = 1'b0;
      arith_cmd.mv = mv_ff;
      case (st_ff)
         sss_pkg::CTL_IDLE: begin
            if (req_valid) begin
               now_in = req_now_ms;
               pon_in = req_power_on_ms;
               chrdy_in = req_channel_ready;
               ok_in = req_read_ok;
               raw_in = req_reading_raw;
               mv_in = req_reading_mv;
               st_in = sss_pkg::CTL_EVAL;
            end
         end
         sss_pkg::CTL_EVAL: begin
            preq_in = active & go_settle;
            prel_in = active & do_sample & cfg.power_switched;
            took_in = active & do_sample & ok_ff;
            if (!active) begin
               status_in = sss_pkg::STATUS_IDLE;
            end else if (do_sample && !ok_ff) begin
               status_in = sss_pkg::STATUS_ERROR;
            end else begin
               status_in = sss_pkg::STATUS_ACTIVE;
            end
            if (active) begin
               settling_in = settle_wait;
            end
            if (active && do_sample && ok_ff) begin
               last_raw_in = raw_ff;
               last_ms_in = now_ff;
               have_in = 1'b1;
               arith_cmd.start = 1'b1;
               st_in = sss_pkg::CTL_WAIT;
            end else begin
               st_in = sss_pkg::CTL_DONE;
            end
         end
         sss_pkg::CTL_WAIT: begin
            if (arith_rsp.done) begin
               last_value_in = arith_rsp.value;
               st_in = sss_pkg::CTL_DONE;
            end
         end
         sss_pkg::CTL_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_preq_in = preq_ff;
               rsp_prel_in = prel_ff;
               rsp_took_in = took_ff;
               rsp_have_in = have_ff;
               rsp_raw_in = last_raw_ff;
               rsp_value_in = last_value_ff;
               st_in = sss_pkg::CTL_IDLE;
            end
         end
         default: begin
            st_in = sss_pkg::CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sss_pkg::CTL_IDLE;
         settling_ff <= 1'b0;
         have_ff <= 1'b0;
         last_ms_ff <= '0;
         last_raw_ff <= '0;
         last_value_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         settling_ff <= settling_in;
         have_ff <= have_in;
         last_ms_ff <= last_ms_in;
         last_raw_ff <= last_raw_in;
         last_value_ff <= last_value_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      pon_ff <= pon_in;
      chrdy_ff <= chrdy_in;
      ok_ff <= ok_in;
      raw_ff <= raw_in;
      mv_ff <= mv_in;
      status_ff <= status_in;
      preq_ff <= preq_in;
      prel_ff <= prel_in;
      took_ff <= took_in;
      rsp_status_ff <= rsp_status_in;
      rsp_preq_ff <= rsp_preq_in;
      rsp_prel_ff <= rsp_prel_in;
      rsp_took_ff <= rsp_took_in;
      rsp_have_ff <= rsp_have_in;
      rsp_raw_ff <= rsp_raw_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_power_request = rsp_preq_ff;
   assign rsp_power_release = rsp_prel_ff;
   assign rsp_sample_taken = rsp_took_ff;
   assign rsp_read_count = READ_COUNT;
   assign rsp_value_valid = rsp_have_ff;
   assign rsp_held_raw = rsp_raw_ff;
   assign rsp_held_value = rsp_value_ff;

`ifndef NO_ASSERTIONS
   // The arithmetic unit only finishes while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> (st_ff == sss_pkg::CTL_WAIT))
      else $error("scaler result arrived outside the wait state");

   // While waiting, the unit is either still working or delivering its result.
   a_wait_has_work: assert property (@(posedge clock) disable iff (reset)
      (st_ff == sss_pkg::CTL_WAIT) |-> (arith_rsp.busy || arith_rsp.done))
      else $error("sequencer waits on an idle arithmetic unit");

   // A failed read never latches a sample.
   a_error_no_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == sss_pkg::STATUS_ERROR)) |-> !rsp_sample_taken)
      else $error("sample latched on a read error");

   // A latched sample always leaves a valid held value.
   a_sample_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_taken) |-> rsp_value_valid)
      else $error("sample taken without a valid held value");
`endif

endmodule
